// ===== rtl/summed_area_table_query_top_defines.svh =====
// assertion macros shared by the summed-area table checker
`ifndef SUMMED_AREA_TABLE_QUERY_TOP_DEFINES_SVH
`define SUMMED_AREA_TABLE_QUERY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SATQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("summed area table check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SATQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("summed area table check failed");

`endif

// ===== rtl/satq_pkg.sv =====
// shared widths, codes and types of the summed-area table query block
package satq_pkg;

	// fixed field widths
	localparam int ELEM_W    = 32;
	localparam int COORD_W   = 9;
	localparam int SUM_W     = 48;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	// register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

	// item commands
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_COORD = 2'd1,
		STATUS_NOT_READY = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_QRY_RD0,
		ST_QRY_RD1,
		ST_QRY_RD2,
		ST_QRY_RD3,
		ST_QRY_ACC,
		ST_QRY_DONE
	} state_t;

endpackage

// ===== rtl/satq_item_if.sv =====
// input item channel: load elements and rectangle queries
interface satq_item_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic signed [satq_pkg::ELEM_W-1:0]  element_value;
	logic        [satq_pkg::COORD_W-1:0] row_top;
	logic        [satq_pkg::COORD_W-1:0] col_left;
	logic        [satq_pkg::COORD_W-1:0] row_bottom;
	logic        [satq_pkg::COORD_W-1:0] col_right;

	modport source (
		output valid, cmd, element_value, row_top, col_left, row_bottom, col_right,
		input  ready
	);

	modport sink (
		input  valid, cmd, element_value, row_top, col_left, row_bottom, col_right,
		output ready
	);
endinterface

// ===== rtl/satq_result_if.sv =====
// result channel: rectangle sum and status of one query
interface satq_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [satq_pkg::SUM_W-1:0]    rect_sum;
	logic        [satq_pkg::STATUS_W-1:0] status;

	modport source (
		output valid, rect_sum, status,
		input  ready
	);

	modport sink (
		input  valid, rect_sum, status,
		output ready
	);
endinterface

// ===== rtl/satq_ram.sv =====
// generic simple dual-port ram with registered read
module satq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 65536
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/summed_area_table_query_top.sv =====
// summed-area table builder and rectangle-sum query engine
// Matrix elements stream in row-major order on the item channel (cmd 0) and each one
// becomes its summed-area entry at once: running row sum plus the entry above. A query
// (cmd 1) returns the inclusive, 1-based rectangle sum from four table reads with status
// 0; status 2 flags a query before the whole table is in, status 1 bad coordinates, and
// then the sum is 0. Loads give no result. The item channel takes one item at a time:
// a load steps through accept, read of the entry above and write, a valid query through
// accept, four reads through the one table read port overlapped with a shared 48-bit
// add/subtract unit, final add and hand-off, a flagged query through accept and hand-off.
// A query also waits while the result register still holds an untaken earlier result.
// Writing either size register restarts loading at row 1, column 1. The table memory
// has no reset and needs no clearing pass.
module summed_area_table_query_top #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	satq_item_if.sink                             items,
	satq_result_if.source                         results,
	input  logic                                  cfg_we,
	input  logic [satq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [satq_pkg::CFG_W-1:0]            cfg_data
);

	localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_A  = (ROWS_W > COLS_W) ? ROWS_W : COLS_W;
	localparam int CMP_W  = (CMP_A > satq_pkg::COORD_W) ? CMP_A : satq_pkg::COORD_W;
	localparam int SUM_W  = satq_pkg::SUM_W;
	localparam int ELEM_W = satq_pkg::ELEM_W;
	localparam int CRD_W  = satq_pkg::COORD_W;

	satq_pkg::state_t  state_q, state_d;
	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROW_IW-1:0] load_row_q;
	logic [COL_IW-1:0] load_col_q;
	logic [SUM_W-1:0]  rsum_q;
	logic              tbl_ready_q;
	logic [SUM_W-1:0]  elem_q;
	logic [CRD_W-1:0]  top_q, left_q, bottom_q, right_q;
	logic [SUM_W-1:0]  acc_q;
	satq_pkg::status_t qstat_q;
	logic              rd_zero_q;
	logic              out_valid_q;
	logic [SUM_W-1:0]  out_sum_q;
	satq_pkg::status_t out_status_q;

	logic              in_fire;
	logic              out_free;
	logic              in_ready;

	// shared add/subtract unit
	logic [SUM_W-1:0]  add_a, add_b, add_sum;
	logic              add_sub;

	// table memory ports
	logic              ram_rd_en, ram_wr_en, rd_zero_d;
	logic [ADDR_W-1:0] ram_rd_addr, ram_wr_addr;
	logic [SUM_W-1:0]  ram_rd_data, rd_val;

	// query coordinate pick for the current read
	logic [CRD_W-1:0]  q_row, q_col, q_row_m1, q_col_m1;
	logic [CRD_W-1:0]  top_m1, left_m1;
	logic [ROW_IW-1:0] above_row;
	logic [ADDR_W-1:0] qry_addr, above_addr;

	// query check at accept
	logic [CMP_W-1:0]  t_ext, l_ext, b_ext, r_ext;
	logic              coord_bad;
	satq_pkg::status_t qstat_d;

	// load position advance
	logic [COLS_W-1:0] col_next;
	logic [ROWS_W-1:0] row_next;

	// size register clamp
	logic [CMP_W-1:0]  cfg_ext;
	logic [ROWS_W-1:0] rows_clamped;
	logic [COLS_W-1:0] cols_clamped;

	assign in_fire  = items.valid && in_ready;
	assign out_free = !out_valid_q || results.ready;

	assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
	assign rd_val  = rd_zero_q ? '0 : ram_rd_data;

	// clamp a size write to 1..max
	assign cfg_ext = CMP_W'(cfg_data);
	always_comb begin
		if (cfg_ext == '0) begin
			rows_clamped = ROWS_W'(1);
			cols_clamped = COLS_W'(1);
		end else begin
			rows_clamped = (cfg_ext > CMP_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : ROWS_W'(cfg_ext);
			cols_clamped = (cfg_ext > CMP_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : COLS_W'(cfg_ext);
		end
	end

	// status of an arriving query
	assign t_ext = CMP_W'(items.row_top);
	assign l_ext = CMP_W'(items.col_left);
	assign b_ext = CMP_W'(items.row_bottom);
	assign r_ext = CMP_W'(items.col_right);
	assign coord_bad = (t_ext == '0) || (l_ext == '0) || (t_ext > b_ext) || (l_ext > r_ext)
		|| (b_ext > CMP_W'(rows_q)) || (r_ext > CMP_W'(cols_q));
	always_comb begin
		if (!tbl_ready_q) begin
			qstat_d = satq_pkg::STATUS_NOT_READY;
		end else if (coord_bad) begin
			qstat_d = satq_pkg::STATUS_BAD_COORD;
		end else begin
			qstat_d = satq_pkg::STATUS_OK;
		end
	end

	// corner selection: bottom-right, top-right, bottom-left, top-left
	assign top_m1  = top_q - CRD_W'(1);
	assign left_m1 = left_q - CRD_W'(1);
	always_comb begin
		q_row = bottom_q;
		q_col = right_q;
		case (state_q)
			satq_pkg::ST_QRY_RD1: begin
				q_row = top_m1;
				q_col = right_q;
			end
			satq_pkg::ST_QRY_RD2: begin
				q_row = bottom_q;
				q_col = left_m1;
			end
			satq_pkg::ST_QRY_RD3: begin
				q_row = top_m1;
				q_col = left_m1;
			end
			default: begin
				q_row = bottom_q;
				q_col = right_q;
			end
		endcase
	end
	assign q_row_m1 = q_row - CRD_W'(1);
	assign q_col_m1 = q_col - CRD_W'(1);
	assign qry_addr = ADDR_W'(q_row_m1) * ADDR_W'(MAX_COLS) + ADDR_W'(q_col_m1);

	// table addresses of a load
	assign above_row   = load_row_q - ROW_IW'(1);
	assign above_addr  = ADDR_W'(above_row) * ADDR_W'(MAX_COLS) + ADDR_W'(load_col_q);
	assign ram_wr_addr = ADDR_W'(load_row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(load_col_q);

	assign col_next = COLS_W'(load_col_q) + COLS_W'(1);
	assign row_next = ROWS_W'(load_row_q) + ROWS_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			satq_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (items.cmd == satq_pkg::CMD_LOAD) begin
						state_d = satq_pkg::ST_LOAD_RD;
					end else if (qstat_d == satq_pkg::STATUS_OK) begin
						state_d = satq_pkg::ST_QRY_RD0;
					end else begin
						state_d = satq_pkg::ST_QRY_DONE;
					end
				end
			end
			satq_pkg::ST_LOAD_RD:  state_d = satq_pkg::ST_LOAD_WR;
			satq_pkg::ST_LOAD_WR:  state_d = satq_pkg::ST_IDLE;
			satq_pkg::ST_QRY_RD0:  state_d = satq_pkg::ST_QRY_RD1;
			satq_pkg::ST_QRY_RD1:  state_d = satq_pkg::ST_QRY_RD2;
			satq_pkg::ST_QRY_RD2:  state_d = satq_pkg::ST_QRY_RD3;
			satq_pkg::ST_QRY_RD3:  state_d = satq_pkg::ST_QRY_ACC;
			satq_pkg::ST_QRY_ACC:  state_d = satq_pkg::ST_QRY_DONE;
			satq_pkg::ST_QRY_DONE: begin
				if (out_free) begin
					state_d = satq_pkg::ST_IDLE;
				end
			end
			default: state_d = satq_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: ready, memory controls, adder operands
	always_comb begin
		in_ready    = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = qry_addr;
		rd_zero_d   = (q_row == '0) || (q_col == '0);
		ram_wr_en   = 1'b0;
		add_a       = acc_q;
		add_b       = rd_val;
		add_sub     = 1'b0;
		unique case (state_q)
			satq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			satq_pkg::ST_LOAD_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = above_addr;
				rd_zero_d   = (load_row_q == '0);
				add_a       = (load_col_q == '0) ? '0 : rsum_q;
				add_b       = elem_q;
			end
			satq_pkg::ST_LOAD_WR: begin
				ram_wr_en = 1'b1;
				add_a     = rsum_q;
				add_b     = rd_val;
			end
			satq_pkg::ST_QRY_RD0: begin
				ram_rd_en = 1'b1;
			end
			satq_pkg::ST_QRY_RD1: begin
				ram_rd_en = 1'b1;
				add_a     = '0;
			end
			satq_pkg::ST_QRY_RD2: begin
				ram_rd_en = 1'b1;
				add_sub   = 1'b1;
			end
			satq_pkg::ST_QRY_RD3: begin
				ram_rd_en = 1'b1;
				add_sub   = 1'b1;
			end
			satq_pkg::ST_QRY_ACC: begin
				add_sub = 1'b0;
			end
			satq_pkg::ST_QRY_DONE: begin
				add_sub = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= satq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sizes, load position and table-ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= ROWS_W'(MAX_ROWS);
			cols_q      <= COLS_W'(MAX_COLS);
			load_row_q  <= '0;
			load_col_q  <= '0;
			rsum_q      <= '0;
			tbl_ready_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				satq_pkg::REG_ROWS_IN_USE: rows_q <= rows_clamped;
				satq_pkg::REG_COLS_IN_USE: cols_q <= cols_clamped;
				default: rows_q <= rows_q;
			endcase
			load_row_q  <= '0;
			load_col_q  <= '0;
			rsum_q      <= '0;
			tbl_ready_q <= 1'b0;
		end else begin
			// a load after a complete table starts a new one
			if (in_fire && items.cmd == satq_pkg::CMD_LOAD && tbl_ready_q) begin
				load_row_q  <= '0;
				load_col_q  <= '0;
				rsum_q      <= '0;
				tbl_ready_q <= 1'b0;
			end
			if (state_q == satq_pkg::ST_LOAD_RD) begin
				rsum_q <= add_sum;
			end
			if (state_q == satq_pkg::ST_LOAD_WR) begin
				if (col_next >= cols_q) begin
					load_col_q <= '0;
					if (row_next >= rows_q) begin
						load_row_q  <= '0;
						tbl_ready_q <= 1'b1;
					end else begin
						load_row_q <= ROW_IW'(row_next);
					end
				end else begin
					load_col_q <= COL_IW'(col_next);
				end
			end
		end
	end

	// item capture and query accumulator
	always_ff @(posedge clk) begin
		if (in_fire) begin
			elem_q   <= {{(SUM_W - ELEM_W){items.element_value[ELEM_W-1]}}, items.element_value};
			top_q    <= items.row_top;
			left_q   <= items.col_left;
			bottom_q <= items.row_bottom;
			right_q  <= items.col_right;
			qstat_q  <= qstat_d;
		end
		if (ram_rd_en) begin
			rd_zero_q <= rd_zero_d;
		end
		if (state_q == satq_pkg::ST_QRY_RD1 || state_q == satq_pkg::ST_QRY_RD2
			|| state_q == satq_pkg::ST_QRY_RD3 || state_q == satq_pkg::ST_QRY_ACC) begin
			acc_q <= add_sum;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == satq_pkg::ST_QRY_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == satq_pkg::ST_QRY_DONE && out_free) begin
			out_sum_q    <= (qstat_q == satq_pkg::STATUS_OK) ? acc_q : '0;
			out_status_q <= qstat_q;
		end
	end

	assign items.ready      = in_ready;
	assign results.valid    = out_valid_q;
	assign results.rect_sum = out_sum_q;
	assign results.status   = out_status_q;

	satq_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (add_sum),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// ===== rtl/satq_checker.sv =====
// port-level checks of the summed-area table block and their bind
`include "summed_area_table_query_top_defines.svh"

module satq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [satq_pkg::SUM_W-1:0]    out_sum,
	input logic [satq_pkg::STATUS_W-1:0] out_status
);

	// a stalled result beat stays offered
	`SATQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// flagged results carry a zero sum
	`SATQ_ASSERT_NOW(a_flag_zero, out_valid && out_status != satq_pkg::STATUS_OK, out_sum == '0)

	// every accepted item keeps the sequencer busy the next cycle
	`SATQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind summed_area_table_query_top satq_checker u_satq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_sum    (results.rect_sum),
	.out_status (results.status)
);

// ===== verif/tb.sv =====
// self-checking testbench of the summed-area table query block
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROWS      = 256;
	localparam int MAX_COLS      = 256;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_ITEMS   = 90;

	typedef struct {
		satq_pkg::cmd_t                     cmd;
		logic signed [satq_pkg::ELEM_W-1:0] value;
		logic [satq_pkg::COORD_W-1:0]       row_t;
		logic [satq_pkg::COORD_W-1:0]       col_l;
		logic [satq_pkg::COORD_W-1:0]       row_b;
		logic [satq_pkg::COORD_W-1:0]       col_r;
	} item_t;

	typedef struct {
		logic [satq_pkg::SUM_W-1:0] rect_sum;
		satq_pkg::status_t          status;
	} answer_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [satq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [satq_pkg::CFG_W-1:0]     cfg_data;

	satq_item_if   item_bus();
	satq_result_if result_bus();

	summed_area_table_query_top #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (item_bus),
		.results  (result_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// shadow copy of the integral image and the load position
	logic [satq_pkg::SUM_W-1:0] sat_mem [MAX_ROWS*MAX_COLS];
	logic [satq_pkg::SUM_W-1:0] row_acc;
	logic [8:0]       next_row;
	logic [8:0]       next_col;
	logic [8:0]       rows_cfg;
	logic [8:0]       cols_cfg;
	bit               table_full;

	answer_t pending_answers[$];

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_left       = 0;
	int items_sent      = 0;
	int answers_checked = 0;
	int builds_done     = 0;
	int fail_count      = 0;
	int cycle_count     = 0;

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [8:0] clamp_size(logic [satq_pkg::CFG_W-1:0] v, int max_size);
		if (v == 0) return 9'd1;
		if (v > max_size) return 9'(max_size);
		return v;
	endfunction

	function automatic void restart_build();
		next_row   = '0;
		next_col   = '0;
		row_acc    = '0;
		table_full = 1'b0;
	endfunction

	// 1-based entry, row or column zero reads as zero
	function automatic logic [satq_pkg::SUM_W-1:0] sat_entry(logic [8:0] r, logic [8:0] c);
		if (r == 0 || c == 0) return '0;
		return sat_mem[(int'(r) - 1) * MAX_COLS + int'(c) - 1];
	endfunction

	function automatic void size_apply(logic [satq_pkg::CFG_IDX_W-1:0] idx,
			logic [satq_pkg::CFG_W-1:0] v);
		if (idx == satq_pkg::REG_ROWS_IN_USE)
			rows_cfg = clamp_size(v, MAX_ROWS);
		else
			cols_cfg = clamp_size(v, MAX_COLS);
		restart_build();
	endfunction

	// update the shadow state for one accepted beat, queue the answer of a query
	function automatic void predict_item(item_t it);
		logic [satq_pkg::SUM_W-1:0] elem;
		answer_t                    ans;
		if (it.cmd == satq_pkg::CMD_LOAD) begin
			if (table_full) restart_build();
			elem = {{(satq_pkg::SUM_W-satq_pkg::ELEM_W){it.value[satq_pkg::ELEM_W-1]}},
				it.value};
			if (next_col == 0) row_acc = '0;
			row_acc = row_acc + elem;
			sat_mem[int'(next_row) * MAX_COLS + int'(next_col)] =
				row_acc + sat_entry(next_row, next_col + 9'd1);
			next_col++;
			if (next_col >= cols_cfg) begin
				next_col = '0;
				next_row++;
				if (next_row >= rows_cfg) begin
					next_row   = '0;
					table_full = 1'b1;
					builds_done++;
				end
			end
		end else begin
			ans.rect_sum = '0;
			if (!table_full) begin
				ans.status = satq_pkg::STATUS_NOT_READY;
			end else if (it.row_t == 0 || it.col_l == 0 || it.row_t > it.row_b ||
					it.col_l > it.col_r || it.row_b > rows_cfg || it.col_r > cols_cfg) begin
				ans.status = satq_pkg::STATUS_BAD_COORD;
			end else begin
				ans.status   = satq_pkg::STATUS_OK;
				ans.rect_sum = sat_entry(it.row_b, it.col_r)
					- sat_entry(it.row_t - 9'd1, it.col_r)
					- sat_entry(it.row_b, it.col_l - 9'd1)
					+ sat_entry(it.row_t - 9'd1, it.col_l - 9'd1);
			end
			pending_answers.insert(pending_answers.size(), ans);
		end
	endfunction

	// result checking against the oldest queued answer
	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result beat: rect_sum %0d, status %0d",
					$signed(result_bus.rect_sum), result_bus.status);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				answers_checked++;
				if (result_bus.rect_sum !== want.rect_sum) begin
					$error("rect_sum: expected %0d, actual %0d",
						$signed(want.rect_sum), $signed(result_bus.rect_sum));
					fail_count++;
				end
				if (result_bus.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result_bus.status);
					fail_count++;
				end
			end
		end
	end

	// result receiver: long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// drive one beat at a falling edge, hold it until accepted
	task automatic send_item(item_t it);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid         <= 1'b1;
		item_bus.cmd           <= it.cmd;
		item_bus.element_value <= it.value;
		item_bus.row_top       <= it.row_t;
		item_bus.col_left      <= it.col_l;
		item_bus.row_bottom    <= it.row_b;
		item_bus.col_right     <= it.col_r;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		predict_item(it);
		items_sent++;
	endtask

	task automatic send_load(logic signed [satq_pkg::ELEM_W-1:0] v);
		item_t it;
		it.cmd   = satq_pkg::CMD_LOAD;
		it.value = v;
		it.row_t = 9'($urandom_range(511));
		it.col_l = 9'($urandom_range(511));
		it.row_b = 9'($urandom_range(511));
		it.col_r = 9'($urandom_range(511));
		send_item(it);
	endtask

	task automatic send_query(logic [8:0] t, logic [8:0] l, logic [8:0] b, logic [8:0] r);
		item_t it;
		it.cmd   = satq_pkg::CMD_QUERY;
		it.value = $urandom;
		it.row_t = t;
		it.col_l = l;
		it.row_b = b;
		it.col_r = r;
		send_item(it);
	endtask

	task automatic park_items();
		@(negedge clk);
		item_bus.valid <= 1'b0;
	endtask

	// idle the sender until all answers are in and the block has settled
	task automatic wait_drain();
		park_items();
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both size registers, raw values so that clamping is exercised
	task automatic set_size(logic [satq_pkg::CFG_W-1:0] raw_rows,
			logic [satq_pkg::CFG_W-1:0] raw_cols);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= satq_pkg::REG_ROWS_IN_USE;
		cfg_data  <= raw_rows;
		@(negedge clk);
		cfg_index <= satq_pkg::REG_COLS_IN_USE;
		cfg_data  <= raw_cols;
		@(negedge clk);
		cfg_we    <= 1'b0;
		size_apply(satq_pkg::REG_ROWS_IN_USE, raw_rows);
		size_apply(satq_pkg::REG_COLS_IN_USE, raw_cols);
	endtask

	function automatic logic signed [satq_pkg::ELEM_W-1:0] pick_element();
		case ($urandom_range(9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [satq_pkg::CFG_W-1:0] pick_size();
		if ($urandom_range(5) == 0) return 9'($urandom_range(12, 6));
		return 9'($urandom_range(5, 1));
	endfunction

	function automatic logic [satq_pkg::CFG_W-1:0] pick_long();
		case ($urandom_range(2))
			0:       return 9'd256;
			1:       return 9'd300;
			default: return 9'd511;
		endcase
	endfunction

	// mostly in-range rectangles, some reversed, oversized or pure noise
	task automatic send_random_query();
		logic [8:0] t, l, b, r;
		t = 9'($urandom_range(rows_cfg, 1));
		b = 9'($urandom_range(rows_cfg, t));
		l = 9'($urandom_range(cols_cfg, 1));
		r = 9'($urandom_range(cols_cfg, l));
		case ($urandom_range(9))
			0: begin
				t = 9'($urandom_range(511));
				l = 9'($urandom_range(511));
				b = 9'($urandom_range(511));
				r = 9'($urandom_range(511));
			end
			1: b = 9'($urandom_range(511, rows_cfg + 1));
			2: r = 9'($urandom_range(511, cols_cfg + 1));
			3: {t, b} = {b, t};
			4: {l, r} = {r, l};
			default: ;
		endcase
		send_query(t, l, b, r);
	endtask

	// one table build with random content followed by queries
	task automatic run_table_round(logic [satq_pkg::CFG_W-1:0] raw_rows,
			logic [satq_pkg::CFG_W-1:0] raw_cols);
		int cells;
		wait_drain();
		set_size(raw_rows, raw_cols);
		cells = rows_cfg * cols_cfg;
		for (int i = 0; i < cells; i++) begin
			// query against a table still being built
			if ($urandom_range(19) == 0) send_random_query();
			// abandoned build, the next size write restarts it
			if (cells <= 64 && i > 0 && $urandom_range(39) == 0) begin
				send_random_query();
				return;
			end
			send_load(pick_element());
		end
		send_query(9'd1, 9'd1, rows_cfg, cols_cfg);
		repeat ($urandom_range(8, 2)) send_random_query();
		// load past a complete table starts a new build
		if ($urandom_range(5) == 0) begin
			send_load(pick_element());
			send_random_query();
		end
	endtask

	task automatic test_not_ready_after_reset();
		send_query(9'd1, 9'd1, 9'd1, 9'd1);
	endtask

	task automatic test_small_table();
		wait_drain();
		set_size(9'd2, 9'd3);
		send_load(32'sh7fffffff);
		send_load(32'sh80000000);
		send_load(-32'sd1);
		send_query(9'd1, 9'd1, 9'd1, 9'd3);
		send_load(32'sd0);
		send_load(32'sd1);
		send_load(32'sh7fffffff);
		// good rectangles
		send_query(9'd1, 9'd1, 9'd2, 9'd3);
		send_query(9'd2, 9'd2, 9'd2, 9'd2);
		send_query(9'd1, 9'd3, 9'd2, 9'd3);
		send_query(9'd2, 9'd1, 9'd2, 9'd2);
		// zero, reversed and out-of-range coordinates
		send_query(9'd0, 9'd1, 9'd1, 9'd1);
		send_query(9'd1, 9'd0, 9'd1, 9'd1);
		send_query(9'd2, 9'd1, 9'd1, 9'd1);
		send_query(9'd1, 9'd3, 9'd1, 9'd2);
		send_query(9'd1, 9'd1, 9'd3, 9'd1);
		send_query(9'd1, 9'd1, 9'd1, 9'd4);
		send_query(9'd511, 9'd511, 9'd511, 9'd511);
		// a further load restarts the build
		send_load(32'sd5);
		send_query(9'd1, 9'd1, 9'd1, 9'd1);
	endtask

	task automatic test_size_restart();
		wait_drain();
		set_size(9'd2, 9'd2);
		send_load(32'sd3);
		send_load(32'sd4);
		wait_drain();
		// zero sizes clamp to one, the write drops the partial build
		set_size(9'd0, 9'd0);
		send_query(9'd1, 9'd1, 9'd1, 9'd1);
		send_load(-32'sd7);
		send_query(9'd1, 9'd1, 9'd1, 9'd1);
		send_query(9'd1, 9'd1, 9'd1, 9'd2);
		send_query(9'd1, 9'd1, 9'd2, 9'd1);
	endtask

	task automatic test_backpressure();
		wait_drain();
		set_size(9'd1, 9'd4);
		repeat (4) send_load(pick_element());
		wait_drain();
		hold_left = 300;
		repeat (10) send_random_query();
		wait_drain();
	endtask

	task automatic test_random_phases();
		int goal;
		for (int p = 0; p < 4; p++) begin
			wait_drain();
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) run_table_round(pick_size(), pick_size());
			// long thin tables reach coordinate 256 and the upper clamp
			if (p == 1) run_table_round(pick_long(), 9'd1);
			if (p == 3) run_table_round(9'd1, pick_long());
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// reset, then the tests in turn
	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = satq_pkg::REG_ROWS_IN_USE;
		cfg_data               = '0;
		item_bus.valid         = 1'b0;
		item_bus.cmd           = satq_pkg::CMD_LOAD;
		item_bus.element_value = '0;
		item_bus.row_top       = '0;
		item_bus.col_left      = '0;
		item_bus.row_bottom    = '0;
		item_bus.col_right     = '0;
		rows_cfg               = 9'(MAX_ROWS);
		cols_cfg               = 9'(MAX_COLS);
		restart_build();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_not_ready_after_reset();
		test_small_table();
		test_size_restart();
		test_backpressure();
		test_random_phases();
		wait_drain();

		$display("%0d beats sent, %0d tables built, %0d query results checked",
			items_sent, builds_done, answers_checked);
		$display("sizes 1x1 to 256-long, bad and early queries, four idle phases, long stall");
		if (fail_count == 0 && pending_answers.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
